[rtl/abm_pkg.sv]
// ----------------------------------------------------------------------------
// abm_pkg: shared types and constants of the angular bin unit
// Field widths, angle constants, operation codes and the records passed
// between the front pipeline, the item queue and the bin store.
// ----------------------------------------------------------------------------
package abm_pkg;

   localparam int ANGLE_W          = 21;      // signed input angle
   localparam int ANG_W            = 19;      // wrapped angle, 0..359999
   localparam int DIST_W           = 12;
   localparam int STR_W            = 8;
   localparam int BIN_W            = 10;      // bin index on the ports
   localparam int CFG_W            = 11;
   localparam int TURN_MDEG        = 360000;
   localparam int RECIP_SHIFT      = 50;      // scale of the 1/360000 reciprocal
   localparam int BIN_COUNT_RESET  = 500;
   localparam int DEFAULT_MAX_BINS = 1024;
   localparam int QDEPTH           = 8;
   localparam int QCNT_W           = $clog2(QDEPTH + 1);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_READ   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOKUP
   } back_state_type;

   // classified item as it travels from front to back
   typedef struct packed {
      op_type              op;
      logic                oob;
      logic [BIN_W-1:0]    bin;
      logic [DIST_W-1:0]   distance;
      logic [STR_W-1:0]    str;
   } side_type;

   // what the front needs to know before it takes an item
   typedef struct packed {
      logic                clearing;
      logic [QCNT_W-1:0]   queue_count;
   } credit_type;

endpackage

[rtl/abm_front.sv]
// ----------------------------------------------------------------------------
// abm_front: input stage and bin index pipeline
// Holds the bin count register, wraps the angle and computes
// floor(angle * bins / 360000) over four stages with a reciprocal multiply.
// ----------------------------------------------------------------------------
module abm_front #(
   parameter int MAX_BINS = abm_pkg::DEFAULT_MAX_BINS,
   localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_operation,
   input  logic signed [abm_pkg::ANGLE_W-1:0]   req_sample_angle,
   input  logic        [abm_pkg::DIST_W-1:0]    req_sample_distance,
   input  logic        [abm_pkg::STR_W-1:0]     req_sample_strength,
   input  logic        [abm_pkg::BIN_W-1:0]     req_read_bin,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [abm_pkg::CFG_W-1:0]     csr_data,
   input  abm_pkg::credit_type                  credit,
   output logic                                 out_valid,
   output abm_pkg::side_type                    out_side,
   output logic        [IDX_W-1:0]              out_addr
);
   import abm_pkg::*;

   localparam int N_W = $clog2(MAX_BINS + 1);
   localparam int P_W = ANG_W + N_W;
   localparam logic [63:0] RECIP = (64'd1 << RECIP_SHIFT) / 64'(TURN_MDEG);
   localparam logic signed [ANGLE_W:0] TURN_S = (ANGLE_W + 1)'(TURN_MDEG);

   logic [CFG_W-1:0]         bin_count_ff;
   logic [3:0]               valid_ff;
   side_type                 side_ff [4];
   logic [N_W-1:0]           n_ff [4];
   logic [ANG_W-1:0]         ang1_ff;
   logic [P_W-1:0]           p2_ff, p3_ff, p4_ff;
   logic [N_W-1:0]           q3_ff, q4_ff;
   logic [P_W-1:0]           m4_ff;

   logic signed [ANGLE_W:0]  a_ext, a_wrap;
   logic [ANG_W-1:0]         ang_in;
   logic [N_W-1:0]           n_in;
   side_type                 side_in;
   logic                     accept;
   logic [2:0]               inflight;
   logic [63:0]              recip_prod;
   logic [P_W-1:0]           rem;
   logic [N_W:0]             q_corr;
   logic [N_W-1:0]           n_m1, q_fin;

   assign csr_ready = 1'b1;

   // credit: everything in flight must find room in the queue
   assign inflight = 3'($countones(valid_ff));
   assign req_full = credit.clearing ||
                     (32'(credit.queue_count) + 32'(inflight) >= QDEPTH);
   assign accept   = req_push && !req_full;

   always_comb begin
      a_ext = (ANGLE_W + 1)'(req_sample_angle);
      priority if (a_ext < 0) begin
         a_wrap = a_ext + TURN_S;
      end else if (a_ext >= TURN_S) begin
         a_wrap = a_ext - TURN_S;
      end else begin
         a_wrap = a_ext;
      end
      priority if (a_wrap < 0) begin
         ang_in = '0;
      end else if (a_wrap >= TURN_S) begin
         ang_in = ANG_W'(TURN_MDEG - 1);
      end else begin
         ang_in = ANG_W'(a_wrap);
      end

      priority if (bin_count_ff == '0) begin
         n_in = N_W'(1);
      end else if (32'(bin_count_ff) > MAX_BINS) begin
         n_in = N_W'(MAX_BINS);
      end else begin
         n_in = N_W'(bin_count_ff);
      end

      side_in.op       = op_type'(req_operation);
      side_in.oob      = (32'(req_read_bin) >= MAX_BINS);
      side_in.bin      = req_read_bin;
      side_in.distance = req_sample_distance;
      side_in.str      = req_sample_strength;
   end

   // estimate is low by at most one, fixed up in the last stage
   assign recip_prod = 64'(p2_ff) * RECIP;

   always_comb begin
      rem    = p4_ff - m4_ff;
      q_corr = (rem >= P_W'(TURN_MDEG)) ? ((N_W + 1)'(q4_ff) + 1'b1)
                                        : (N_W + 1)'(q4_ff);
      n_m1   = n_ff[3] - 1'b1;
      if (q_corr > (N_W + 1)'(n_m1)) begin
         q_fin = n_m1;
      end else begin
         q_fin = N_W'(q_corr);
      end

      out_valid = valid_ff[3];
      out_side  = side_ff[3];
      unique case (side_ff[3].op)
         OP_INSERT: begin
            out_addr     = IDX_W'(q_fin);
            out_side.bin = BIN_W'(q_fin);
         end
         OP_READ: begin
            out_addr     = IDX_W'(side_ff[3].bin);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= CFG_W'(BIN_COUNT_RESET);
         valid_ff     <= '0;
      end else begin
         if (csr_valid) begin
            bin_count_ff <= csr_data;
         end
         valid_ff <= {valid_ff[2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      side_ff[1] <= side_ff[0];
      side_ff[2] <= side_ff[1];
      side_ff[3] <= side_ff[2];
      n_ff[0]    <= n_in;
      n_ff[1]    <= n_ff[0];
      n_ff[2]    <= n_ff[1];
      n_ff[3]    <= n_ff[2];
      ang1_ff    <= ang_in;
      p2_ff      <= P_W'(ang1_ff) * P_W'(n_ff[0]);
      q3_ff      <= recip_prod[RECIP_SHIFT +: N_W];
      p3_ff      <= p2_ff;
      m4_ff      <= P_W'(q3_ff) * P_W'(TURN_MDEG);
      q4_ff      <= q3_ff;
      p4_ff      <= p3_ff;
   end

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      32'(credit.queue_count) + 32'(inflight) <= QDEPTH)
      else $error("front has more items in flight than queue room");

endmodule

[rtl/abm_queue.sv]
// ----------------------------------------------------------------------------
// abm_queue: short item queue between front and back
// Register-based first-in first-out buffer with an occupancy count.
// ----------------------------------------------------------------------------
module abm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = abm_pkg::QDEPTH,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [WIDTH-1:0]  push_data,
   input  logic              pop,
   output logic [WIDTH-1:0]  pop_data,
   output logic              empty,
   output logic [CNT_W-1:0]  count
);
   import abm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0]  entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNT_W'(DEPTH)))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

[rtl/abm_back.sv]
// ----------------------------------------------------------------------------
// abm_back: bin store and result register
// Clears the store after reset, then takes one item at a time from the
// queue: reads the bin, applies the insert or read-and-clear rule, writes
// the bin back and holds the result until it is taken.
// ----------------------------------------------------------------------------
module abm_back #(
   parameter int MAX_BINS = abm_pkg::DEFAULT_MAX_BINS,
   localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  abm_pkg::side_type                q_side,
   input  logic [IDX_W-1:0]                 q_addr,
   output logic                             q_pop,
   output logic                             clearing,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [abm_pkg::BIN_W-1:0]        rsp_bin_index,
   output logic                             rsp_bin_filled,
   output logic [abm_pkg::DIST_W-1:0]       rsp_bin_distance,
   output logic [abm_pkg::STR_W-1:0]        rsp_bin_strength,
   output logic                             rsp_sample_taken
);
   import abm_pkg::*;

   localparam int MW = 1 + DIST_W + STR_W;

   // word: valid, distance, strength
   logic [MW-1:0]        bins_ff [MAX_BINS];
   logic [MW-1:0]        rd_data_ff;
   back_state_type       state_ff, state_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   side_type             ent_ff, ent_in;
   logic [IDX_W-1:0]     addr_ff, addr_in;
   logic                 out_valid_ff, out_valid_in;
   logic [BIN_W-1:0]     out_bin_ff, out_bin_in;
   logic                 out_filled_ff, out_filled_in;
   logic [DIST_W-1:0]    out_dist_ff, out_dist_in;
   logic [STR_W-1:0]     out_str_ff, out_str_in;
   logic                 out_taken_ff, out_taken_in;

   logic                 rd_en, wr_en, load;
   logic [IDX_W-1:0]     wr_addr;
   logic [MW-1:0]        wr_data;
   logic                 st_valid;
   logic [DIST_W-1:0]    st_dist;
   logic [STR_W-1:0]     st_str;

   assign st_valid = rd_data_ff[MW-1];
   assign st_dist  = rd_data_ff[STR_W +: DIST_W];
   assign st_str   = rd_data_ff[STR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ent_in        = ent_ff;
      addr_in       = addr_ff;
      q_pop         = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = '0;
      load          = 1'b0;
      out_bin_in    = ent_ff.bin;
      out_filled_in = 1'b0;
      out_dist_in   = '0;
      out_str_in    = '0;
      out_taken_in  = 1'b0;

      unique case (state_ff)
         BK_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == IDX_W'(MAX_BINS - 1)) begin
               state_in = BK_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               rd_en    = 1'b1;
               ent_in   = q_side;
               addr_in  = q_addr;
               state_in = BK_LOOKUP;
            end
         end
         BK_LOOKUP: begin
            // wait here while the previous result is still unread
            if (!out_valid_ff || rsp_pop) begin
               load     = 1'b1;
               state_in = BK_IDLE;
               unique case (ent_ff.op)
                  OP_INSERT: begin
                     out_filled_in = 1'b1;
                     if (!st_valid || (ent_ff.distance < st_dist)) begin
                        out_taken_in = 1'b1;
                        out_dist_in  = ent_ff.distance;
                        out_str_in   = ent_ff.str;
                        wr_en        = 1'b1;
                        wr_data      = {1'b1, ent_ff.distance, ent_ff.str};
                     end else begin
                        out_dist_in  = st_dist;
                        out_str_in   = st_str;
                     end
                  end
                  OP_READ: begin
                     if (!ent_ff.oob && st_valid) begin
                        out_filled_in = 1'b1;
                        out_dist_in   = st_dist;
                        out_str_in    = st_str;
                        wr_en         = 1'b1;
                        wr_data       = {1'b0, st_dist, st_str};
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase

      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign clearing         = (state_ff == BK_CLEAR);
   assign rsp_empty        = !out_valid_ff;
   assign rsp_bin_index    = out_bin_ff;
   assign rsp_bin_filled   = out_filled_ff;
   assign rsp_bin_distance = out_dist_ff;
   assign rsp_bin_strength = out_str_ff;
   assign rsp_sample_taken = out_taken_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      addr_ff <= addr_in;
      if (load) begin
         out_bin_ff    <= out_bin_in;
         out_filled_ff <= out_filled_in;
         out_dist_ff   <= out_dist_in;
         out_str_ff    <= out_str_in;
         out_taken_ff  <= out_taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bins_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bins_ff[q_addr];
      end
   end

   a_clear_no_items: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> q_empty)
      else $error("item reached the queue during the clearing pass");

   a_pop_then_lookup: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == BK_LOOKUP))
      else $error("queue item taken without a store lookup");

   a_taken_is_filled: assert property (@(posedge clock) disable iff (reset)
      (load && out_taken_in) |-> (out_filled_in && (ent_ff.op == OP_INSERT)))
      else $error("sample taken on a result that is not a filled insert");

endmodule

[rtl/lidar_angular_bin_min_range_unit.sv]
// ----------------------------------------------------------------------------
// lidar_angular_bin_min_range_unit: nearest range per angular bin
// Bins lidar samples by angle and keeps the nearest distance and its
// strength in each bin; read items return one bin and empty it.
//
//   channel  direction  handshake        payload
//   req_     in         push / full      operation, angle, distance, strength, bin
//   rsp_     out        empty / pop      bin index, filled, distance, strength, taken
//   csr_     in         valid / ready    bin count (11 bits)
//
// An item passes through the index pipeline (angle wrap, bins multiply,
// reciprocal multiply, remainder fix-up), then the bin store handles one
// item at a time (registered read, then update) and takes no new item until
// the last is written back, set by the single-port read-modify-write of the store.
// After reset the store is cleared one bin a cycle, all MAX_BINS bins, with
// req_full high; csr writes are taken at any time.
// An unread result holds the store; the queue keeps taking items until full.
// ----------------------------------------------------------------------------
module lidar_angular_bin_min_range_unit #(
   parameter int MAX_BINS = abm_pkg::DEFAULT_MAX_BINS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_operation,
   input  logic signed [abm_pkg::ANGLE_W-1:0]   req_sample_angle,
   input  logic        [abm_pkg::DIST_W-1:0]    req_sample_distance,
   input  logic        [abm_pkg::STR_W-1:0]     req_sample_strength,
   input  logic        [abm_pkg::BIN_W-1:0]     req_read_bin,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic        [abm_pkg::BIN_W-1:0]     rsp_bin_index,
   output logic                                 rsp_bin_filled,
   output logic        [abm_pkg::DIST_W-1:0]    rsp_bin_distance,
   output logic        [abm_pkg::STR_W-1:0]     rsp_bin_strength,
   output logic                                 rsp_sample_taken,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [abm_pkg::CFG_W-1:0]     csr_data
);
   import abm_pkg::*;

   localparam int IDX_W  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int SIDE_W = $bits(side_type);
   localparam int QW     = IDX_W + SIDE_W;

   credit_type          credit;
   logic                f_valid;
   side_type            f_side;
   logic [IDX_W-1:0]    f_addr;
   logic [QW-1:0]       q_push_data, q_pop_data;
   logic                q_pop, q_empty;
   logic [QCNT_W-1:0]   q_count;
   logic                clearing;

   assign credit.clearing    = clearing;
   assign credit.queue_count = q_count;
   assign q_push_data        = {f_addr, f_side};

   abm_front #(.MAX_BINS(MAX_BINS)) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_operation       (req_operation),
      .req_sample_angle    (req_sample_angle),
      .req_sample_distance (req_sample_distance),
      .req_sample_strength (req_sample_strength),
      .req_read_bin        (req_read_bin),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_data            (csr_data),
      .credit              (credit),
      .out_valid           (f_valid),
      .out_side            (f_side),
      .out_addr            (f_addr)
   );

   abm_queue #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty),
      .count     (q_count)
   );

   abm_back #(.MAX_BINS(MAX_BINS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_side           (side_type'(q_pop_data[SIDE_W-1:0])),
      .q_addr           (q_pop_data[QW-1:SIDE_W]),
      .q_pop            (q_pop),
      .clearing         (clearing),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_bin_index    (rsp_bin_index),
      .rsp_bin_filled   (rsp_bin_filled),
      .rsp_bin_distance (rsp_bin_distance),
      .rsp_bin_strength (rsp_bin_strength),
      .rsp_sample_taken (rsp_sample_taken)
   );

endmodule
